/* sv/rrss_pkg.sv */
// Types and constants shared by the round-robin sleep scheduler modules.
`default_nettype none
package rrss_pkg;

   localparam int unsigned SLOT_W   = 6;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned MS_W     = 32;
   localparam int unsigned PROD_W   = MS_W + 10;
   localparam int unsigned US_PER_MS = 1000;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [TIME_W-1:0]  time_type;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_START  = 2'd1,
      CMD_SWITCH = 2'd2,
      CMD_SLEEP  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_SLEEP,
      ST_DONE
   } state_type;

   // Broadcast from the controller to every cell of the ring.
   typedef struct packed {
      logic      load;
      logic      shift;
      logic      wr;
      logic      wr_blocked;
      time_type  wr_wake;
      slot_type  sel;
      count_type count;
      time_type  now;
   } cell_ctl_type;

   typedef struct packed {
      logic     hit;
      slot_type hit_slot;
   } scan_status_type;

endpackage
`default_nettype wire

/* sv/rrss_cell.sv */
// One task slot: blocked flag, wake time and the scan token of the ring.
`default_nettype none
module rrss_cell #(
   parameter int unsigned ID = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rrss_pkg::cell_ctl_type ctl,
   input  wire logic                  token_in,
   output logic                       token_out,
   output logic                       last,
   output logic                       hit
);

   logic                blocked_ff, blocked_in;
   rrss_pkg::time_type  wake_ff, wake_in;
   logic                token_ff, token_in_nxt;
   logic                mine;

   assign mine      = (ctl.sel == rrss_pkg::slot_type'(ID));
   assign last      = (ctl.count == rrss_pkg::count_type'(ID + 1));
   assign token_out = token_ff;
   // A visited slot takes the token when it is ready or its wake time has passed.
   assign hit = ctl.shift & token_in & (~blocked_ff | (ctl.now >= wake_ff));

   always_comb begin
      blocked_in   = blocked_ff;
      wake_in      = wake_ff;
      token_in_nxt = 1'b0;
      if (ctl.wr && mine) begin
         blocked_in = ctl.wr_blocked;
         wake_in    = ctl.wr_wake;
      end else if (hit) begin
         blocked_in = 1'b0;
      end
      if (ctl.load) begin
         token_in_nxt = mine;
      end else if (ctl.shift) begin
         token_in_nxt = token_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= 1'b0;
         token_ff   <= 1'b0;
      end else begin
         blocked_ff <= blocked_in;
         token_ff   <= token_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      wake_ff <= wake_in;
   end

endmodule
`default_nettype wire

/* sv/rrss_ctrl.sv */
// Command sequencer: task count, current slot, sleep arithmetic and result register.
`default_nettype none
module rrss_ctrl #(
   parameter int unsigned MAX_TASKS = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_cmd,
   input  wire logic [63:0]               req_now_us,
   input  wire logic [31:0]               req_sleep_ms,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [5:0]                     rsp_task_index,
   output logic                           rsp_ok,
   output logic [6:0]                     rsp_count,
   output rrss_pkg::cell_ctl_type         cell_ctl,
   input  wire rrss_pkg::scan_status_type scan_status
);

   localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

   rrss_pkg::state_type          state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]             current_ff, current_in;
   logic                         running_ff, running_in;
   logic [IDX_W-1:0]             step_ff, step_in;
   rrss_pkg::time_type           now_ff, now_in;
   logic [rrss_pkg::MS_W-1:0]    ms_ff, ms_in;
   logic [rrss_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [IDX_W-1:0]             res_index_ff, res_index_in;
   logic                         res_ok_ff, res_ok_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [5:0]                   rsp_index_ff, rsp_index_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [6:0]                   rsp_count_ff, rsp_count_in;
   logic                         full;
   logic                         rsp_free;

   assign full      = (count_ff == CNT_W'(MAX_TASKS));
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != rrss_pkg::ST_IDLE);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_task_index = rsp_index_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_count      = rsp_count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      current_in   = current_ff;
      running_in   = running_ff;
      step_in      = step_ff;
      now_in       = now_ff;
      ms_in        = ms_ff;
      prod_in      = prod_ff;
      res_index_in = res_index_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;

      cell_ctl            = '0;
      cell_ctl.count      = rrss_pkg::count_type'(count_ff);
      cell_ctl.now        = now_ff;
      cell_ctl.sel        = rrss_pkg::slot_type'(current_ff);

      unique case (state_ff)
         rrss_pkg::ST_IDLE: begin
            if (req_valid) begin
               now_in       = req_now_us;
               ms_in        = req_sleep_ms;
               res_index_in = current_ff;
               res_ok_in    = 1'b1;
               state_in     = rrss_pkg::ST_DONE;
               unique case (rrss_pkg::cmd_type'(req_cmd))
                  rrss_pkg::CMD_ADD: begin
                     if (full) begin
                        res_ok_in = 1'b0;
                     end else begin
                        cell_ctl.wr         = 1'b1;
                        cell_ctl.wr_blocked = 1'b0;
                        cell_ctl.wr_wake    = '0;
                        cell_ctl.sel        = rrss_pkg::slot_type'(count_ff);
                        res_index_in        = IDX_W'(count_ff);
                        count_in            = count_ff + CNT_W'(1);
                     end
                  end
                  rrss_pkg::CMD_START: begin
                     current_in   = (count_ff > CNT_W'(1)) ? IDX_W'(1) : '0;
                     running_in   = 1'b1;
                     res_index_in = current_in;
                  end
                  rrss_pkg::CMD_SWITCH: begin
                     if (count_ff == CNT_W'(1)) begin
                        current_in   = '0;
                        running_in   = 1'b1;
                        res_index_in = '0;
                     end else begin
                        // Park the token on the current slot; the scan starts one past it.
                        cell_ctl.load = 1'b1;
                        step_in       = IDX_W'(1);
                        state_in      = rrss_pkg::ST_SCAN;
                     end
                  end
                  rrss_pkg::CMD_SLEEP: begin
                     if (!running_ff) begin
                        res_ok_in = 1'b0;
                     end else begin
                        state_in = rrss_pkg::ST_MUL;
                     end
                  end
                  default: begin
                     res_ok_in = 1'b0;
                  end
               endcase
            end
         end
         rrss_pkg::ST_SCAN: begin
            cell_ctl.shift = 1'b1;
            if (scan_status.hit) begin
               current_in = scan_status.hit_slot[IDX_W-1:0];
               running_in = 1'b1;
               state_in   = rrss_pkg::ST_DONE;
            end else if (CNT_W'(step_ff) == count_ff - CNT_W'(1)) begin
               current_in = '0;
               running_in = 1'b1;
               state_in   = rrss_pkg::ST_DONE;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
            res_index_in = current_in;
         end
         rrss_pkg::ST_MUL: begin
            prod_in  = rrss_pkg::PROD_W'(ms_ff) * rrss_pkg::PROD_W'(rrss_pkg::US_PER_MS);
            state_in = rrss_pkg::ST_SLEEP;
         end
         rrss_pkg::ST_SLEEP: begin
            cell_ctl.wr         = 1'b1;
            cell_ctl.wr_blocked = 1'b1;
            cell_ctl.wr_wake    = now_ff + rrss_pkg::time_type'(prod_ff);
            state_in            = rrss_pkg::ST_DONE;
         end
         rrss_pkg::ST_DONE: begin
            // Hold the result until the output register is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = 6'(res_index_ff);
               rsp_ok_in    = res_ok_ff;
               rsp_count_in = 7'(count_ff);
               state_in     = rrss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrss_pkg::ST_IDLE;
         count_ff     <= CNT_W'(1);
         current_ff   <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         current_ff   <= current_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      now_ff       <= now_in;
      ms_ff        <= ms_in;
      prod_ff      <= prod_in;
      res_index_ff <= res_index_in;
      res_ok_ff    <= res_ok_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   a_current_in_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(current_ff) < count_ff)
      else $error("current slot beyond registered count");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      ##1 count_ff >= $past(count_ff))
      else $error("task count decreased");

   a_scan_needs_tasks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrss_pkg::ST_SCAN) |-> (count_ff > CNT_W'(1)))
      else $error("scan started with a single task");

endmodule
`default_nettype wire

/* sv/round_robin_sleep_scheduler.sv */
// Round-robin task scheduler top level: controller and ring of task-slot cells.
//
// Each command gives one result. Add, start and a sleep before start go from the idle
// state straight to the done state; sleep first passes a registered ms*1000 multiply,
// then the wake-time add. A switch with a single task also goes straight to done;
// otherwise the token scans from one past the current slot, visiting at most count-1
// slots: it moves one cell per cycle around the ring of task cells, wrapping at the
// registered count, and stops at the first ready slot, else selects slot 0. The next
// command is taken in the cycle after the result is loaded into the output register.
`default_nettype none
module round_robin_sleep_scheduler #(
   parameter int unsigned MAX_TASKS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [63:0] req_now_us,
   input  wire logic [31:0] req_sleep_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_task_index,
   output logic             rsp_ok,
   output logic [6:0]       rsp_count
);

   rrss_pkg::cell_ctl_type    cell_ctl;
   rrss_pkg::scan_status_type scan_status;
   logic [MAX_TASKS-1:0]      token_in;
   logic [MAX_TASKS-1:0]      token_out;
   logic [MAX_TASKS-1:0]      last;
   logic [MAX_TASKS-1:0]      hit;

   rrss_ctrl #(
      .MAX_TASKS(MAX_TASKS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_now_us     (req_now_us),
      .req_sleep_ms   (req_sleep_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_task_index (rsp_task_index),
      .rsp_ok         (rsp_ok),
      .rsp_count      (rsp_count),
      .cell_ctl       (cell_ctl),
      .scan_status    (scan_status)
   );

   // Wrap the token from the last registered slot back to slot 0.
   assign token_in[0] = |(token_out & last);

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign token_in[i] = token_out[i-1] & ~last[i-1];
      end
      rrss_cell #(
         .ID(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .token_in  (token_in[i]),
         .token_out (token_out[i]),
         .last      (last[i]),
         .hit       (hit[i])
      );
   end

   always_comb begin
      scan_status.hit      = |hit;
      scan_status.hit_slot = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (hit[i]) begin
            scan_status.hit_slot = scan_status.hit_slot | rrss_pkg::slot_type'(i);
         end
      end
   end

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_out))
      else $error("more than one scan token in the ring");

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit))
      else $error("more than one slot selected in a scan cycle");

endmodule
`default_nettype wire

/* tb/round_robin_sleep_scheduler_test.sv */
// Self-checking testbench for the round-robin sleep scheduler: directed table, then random traffic.
`timescale 1ns / 100ps
module round_robin_sleep_scheduler_test;

   localparam int unsigned MAX_TASKS  = 8;
   localparam int unsigned NUM_PHASES = 5;
   localparam int unsigned PHASE_CMDS = 246;
   localparam int unsigned HOLD_LEN   = 300;
   localparam int unsigned TAIL_LEN   = 40;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      rrss_pkg::slot_type  task_index;
      logic                ok;
      rrss_pkg::count_type count;
   } sched_result_type;

   typedef struct packed {
      rrss_pkg::cmd_type  cmd;
      rrss_pkg::time_type now;
      logic [31:0]        ms;
      logic               fixed;
      sched_result_type   want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = 2'd0;
   logic [63:0] req_now_us = 64'd0;
   logic [31:0] req_sleep_ms = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_task_index;
   logic        rsp_ok;
   logic [6:0]  rsp_count;

   // Scheduler shadow state
   logic               slot_asleep [MAX_TASKS];
   rrss_pkg::time_type slot_wake   [MAX_TASKS];
   int unsigned        task_total;
   int unsigned        active_slot;
   logic               started;

   sched_result_type   pending_results[$];
   sched_result_type   head_result;
   int unsigned        fail_count  = 0;
   int unsigned        cycle_count = 0;
   int unsigned        gap_pct     = 0;
   int unsigned        stall_pct   = 0;
   bit                 hold_request = 1'b0;
   int unsigned        hold_left    = 0;
   rrss_pkg::time_type uptime_us    = '0;

   stim_row_type directed_rows [0:21] = '{
      '{rrss_pkg::CMD_SLEEP,  64'd0, 32'd0, 1'b1, '{6'd0, 1'b0, 7'd1}},
      '{rrss_pkg::CMD_SWITCH, 64'd0, 32'd0, 1'b1, '{6'd0, 1'b1, 7'd1}},
      '{rrss_pkg::CMD_SLEEP,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{6'd0, 1'b1, 7'd1}},
      '{rrss_pkg::CMD_SWITCH, 64'd0, 32'd0, 1'b1, '{6'd0, 1'b1, 7'd1}},
      '{rrss_pkg::CMD_START,  64'd0, 32'd0, 1'b1, '{6'd0, 1'b1, 7'd1}},
      '{rrss_pkg::CMD_ADD,    64'd0, 32'd0, 1'b1, '{6'd1, 1'b1, 7'd2}},
      '{rrss_pkg::CMD_ADD,    64'd0, 32'd0, 1'b1, '{6'd2, 1'b1, 7'd3}},
      '{rrss_pkg::CMD_ADD,    64'd0, 32'd0, 1'b1, '{6'd3, 1'b1, 7'd4}},
      '{rrss_pkg::CMD_ADD,    64'd0, 32'd0, 1'b1, '{6'd4, 1'b1, 7'd5}},
      '{rrss_pkg::CMD_ADD,    64'd0, 32'd0, 1'b1, '{6'd5, 1'b1, 7'd6}},
      '{rrss_pkg::CMD_ADD,    64'd0, 32'd0, 1'b1, '{6'd6, 1'b1, 7'd7}},
      '{rrss_pkg::CMD_ADD,    64'd0, 32'd0, 1'b1, '{6'd7, 1'b1, 7'd8}},
      '{rrss_pkg::CMD_ADD,    64'd0, 32'd0, 1'b1, '{6'd0, 1'b0, 7'd8}},
      '{rrss_pkg::CMD_START,  64'd0, 32'd0, 1'b1, '{6'd1, 1'b1, 7'd8}},
      '{rrss_pkg::CMD_START,  64'd0, 32'd0, 1'b1, '{6'd1, 1'b1, 7'd8}},
      '{rrss_pkg::CMD_SLEEP,  64'd0, 32'hFFFF_FFFF, 1'b0, '0},
      '{rrss_pkg::CMD_SWITCH, 64'd0, 32'd0, 1'b0, '0},
      '{rrss_pkg::CMD_SLEEP,  64'hFFFF_FFFF_FFFF_FC18, 32'd1, 1'b0, '0},
      '{rrss_pkg::CMD_SWITCH, 64'd0, 32'd0, 1'b0, '0},
      '{rrss_pkg::CMD_SLEEP,  64'd0, 32'd0, 1'b0, '0},
      '{rrss_pkg::CMD_SWITCH, 64'd0, 32'd0, 1'b0, '0},
      '{rrss_pkg::CMD_SWITCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, '0}
   };

   round_robin_sleep_scheduler #(
      .MAX_TASKS(MAX_TASKS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_now_us(req_now_us),
      .req_sleep_ms(req_sleep_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_task_index(rsp_task_index),
      .rsp_ok(rsp_ok),
      .rsp_count(rsp_count)
   );

   always #4 clock = ~clock;

   function automatic sched_result_type schedule_step(rrss_pkg::cmd_type cmd,
                                                      rrss_pkg::time_type now,
                                                      logic [31:0] ms);
      sched_result_type   res;
      int unsigned        n;
      int unsigned        idx;
      int unsigned        i;
      bit                 found;
      rrss_pkg::time_type delay_us;
      if (active_slot >= MAX_TASKS || active_slot >= task_total) active_slot = 0;
      res.task_index = rrss_pkg::slot_type'(active_slot);
      res.ok = 1'b1;
      case (cmd)
         rrss_pkg::CMD_ADD: begin
            if (task_total >= MAX_TASKS) begin
               res.ok = 1'b0;
            end else begin
               res.task_index = rrss_pkg::slot_type'(task_total);
               slot_wake[task_total] = '0;
               slot_asleep[task_total] = 1'b0;
               task_total++;
            end
         end
         rrss_pkg::CMD_START: begin
            active_slot = (task_total > 1) ? 1 : 0;
            started = 1'b1;
            res.task_index = rrss_pkg::slot_type'(active_slot);
         end
         rrss_pkg::CMD_SWITCH: begin
            n = task_total;
            idx = active_slot;
            found = 1'b0;
            // walk the ring from the current slot, waking expired sleepers
            for (i = 1; i < n && !found; i++) begin
               idx = (idx + 1) % n;
               if (slot_asleep[idx] && now >= slot_wake[idx]) slot_asleep[idx] = 1'b0;
               if (!slot_asleep[idx]) begin
                  active_slot = idx;
                  found = 1'b1;
               end
            end
            if (!found) active_slot = 0;
            started = 1'b1;
            res.task_index = rrss_pkg::slot_type'(active_slot);
         end
         default: begin
            if (!started) begin
               res.ok = 1'b0;
            end else begin
               delay_us = rrss_pkg::time_type'(ms) *
                          rrss_pkg::time_type'(rrss_pkg::US_PER_MS);
               slot_wake[active_slot] = now + delay_us;
               slot_asleep[active_slot] = 1'b1;
            end
         end
      endcase
      res.count = rrss_pkg::count_type'(task_total);
      return res;
   endfunction

   task automatic send_cmd(input stim_row_type row);
      sched_result_type predicted;
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_cmd      <= row.cmd;
      req_now_us   <= row.now;
      req_sleep_ms <= row.ms;
      do @(posedge clock); while (req_stall);
      predicted = schedule_step(row.cmd, row.now, row.ms);
      pending_results.push_back(row.fixed ? row.want : predicted);
   endtask

   task automatic random_cmd();
      stim_row_type row;
      int unsigned  pick;
      row = '0;
      pick = $urandom_range(99);
      if (pick < 8)       row.cmd = rrss_pkg::CMD_ADD;
      else if (pick < 16) row.cmd = rrss_pkg::CMD_START;
      else if (pick < 56) row.cmd = rrss_pkg::CMD_SWITCH;
      else                row.cmd = rrss_pkg::CMD_SLEEP;
      pick = $urandom_range(99);
      if (pick < 65)      row.ms = $urandom_range(50);
      else if (pick < 90) row.ms = $urandom_range(2000);
      else                row.ms = $urandom;
      // mostly a steadily advancing clock, sometimes a wild timestamp
      if ($urandom_range(99) < 90) begin
         uptime_us = uptime_us + rrss_pkg::time_type'($urandom_range(2000));
         row.now = uptime_us;
      end else begin
         row.now = {$urandom, $urandom};
      end
      send_cmd(row);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
   endtask

   // Receiver stall, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_LEN;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transfer: task_index %0d ok %0d count %0d",
                   rsp_task_index, rsp_ok, rsp_count);
            fail_count++;
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_task_index !== head_result.task_index) begin
               $error("task_index: expected %0d, got %0d", head_result.task_index,
                      rsp_task_index);
               fail_count++;
            end
            if (rsp_ok !== head_result.ok) begin
               $error("ok: expected %0d, got %0d", head_result.ok, rsp_ok);
               fail_count++;
            end
            if (rsp_count !== head_result.count) begin
               $error("count: expected %0d, got %0d", head_result.count, rsp_count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned ph;
      int unsigned k;
      for (k = 0; k < MAX_TASKS; k++) begin
         slot_asleep[k] = 1'b0;
         slot_wake[k] = '0;
      end
      task_total = 1;
      active_slot = 0;
      started = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) send_cmd(directed_rows[r]);
      drain_results();

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 49; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 49; end
            3: begin gap_pct = 28; stall_pct = 28; end
            default: begin
               // back up the output while commands keep coming
               gap_pct = 0;
               stall_pct = 0;
               hold_request = 1'b1;
            end
         endcase
         for (k = 0; k < PHASE_CMDS; k++) random_cmd();
         drain_results();
      end

      repeat (TAIL_LEN) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
